// ----- hdl/bccp_pkg.sv -----
// Shared types for the box versus upright cylinder collision pipeline.
package bccp_pkg;

    // Per-beat control flags that ride along the pipeline.
    typedef struct packed {
        logic hit;    // box and cylinder overlap
        logic s_nz;   // horizontal distance is nonzero
        logic use_h;  // push along the horizontal direction
        logic sx;     // dx negative
        logic sz;     // dz negative
    } bccp_ctl_t;

endpackage

// ----- hdl/bccp_front.sv -----
// Front end: footprint clamp, squared distance, overlap tests, vertical push.
module bccp_front #(
    parameter int W = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic signed [W-1:0]       cyl_x,
    input  logic signed [W-1:0]       cyl_y,
    input  logic signed [W-1:0]       cyl_z,
    input  logic        [W-2:0]       cyl_radius,
    input  logic        [W-2:0]       cyl_height,
    input  logic signed [W-1:0]       box_min_x,
    input  logic signed [W-1:0]       box_min_y,
    input  logic signed [W-1:0]       box_min_z,
    input  logic signed [W-1:0]       box_max_x,
    input  logic signed [W-1:0]       box_max_y,
    input  logic signed [W-1:0]       box_max_z,
    output logic                      out_vld,
    output logic        [2*W-3:0]     s,
    output bccp_pkg::bccp_ctl_t       ctl,
    output logic        [W-2:0]       ax,
    output logic        [W-2:0]       az,
    output logic        [W-2:0]       rad,
    output logic        [W-1:0]       vpush,
    output logic        [W-1:0]       vmag
);
    import bccp_pkg::*;

    localparam int M = W - 1;

    function automatic logic signed [W-1:0] clamp_c(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] lo,
        input logic signed [W-1:0] hi
    );
        logic signed [W-1:0] c;
        begin
            c = (x < lo) ? lo : x;
            return (c > hi) ? hi : c;
        end
    endfunction

    // stage A
    logic              a_vld_reg;
    logic signed [W:0] a_dx_reg, a_dz_reg, a_top_reg, a_up_reg;
    logic signed [W-1:0] a_ny_reg;
    logic              a_cylt_reg;
    logic [M-1:0]      a_rad_reg;
    logic signed [W-1:0] cx_c, cz_c;

    // stage B
    logic                b_vld_reg;
    logic [2*W-1:0]      b_sqx_reg, b_sqz_reg;
    logic [2*M-1:0]      b_rad2_reg;
    logic signed [W+1:0] b_up_reg, b_down_reg;
    logic                b_vert_reg, b_sx_reg, b_sz_reg;
    logic [M-1:0]        b_ax_reg, b_az_reg, b_rad_reg;
    logic [W-1:0]        ax_w, az_w;
    logic signed [W:0]   ny_ext;

    // stage C
    logic                c_vld_reg;
    logic [2*M-1:0]      c_s_reg;
    bccp_ctl_t           c_ctl_reg;
    logic [M-1:0]        c_ax_reg, c_az_reg, c_rad_reg;
    logic [W-1:0]        c_vpush_reg, c_vmag_reg;
    logic [2*W:0]        s_sum;
    logic                horiz, up_lt;
    logic signed [W+1:0] up_half, down_half;

    assign cx_c = clamp_c(cyl_x, box_min_x, box_max_x);
    assign cz_c = clamp_c(cyl_z, box_min_z, box_max_z);

    assign ax_w   = a_dx_reg[W] ? W'(-a_dx_reg) : a_dx_reg[W-1:0];
    assign az_w   = a_dz_reg[W] ? W'(-a_dz_reg) : a_dz_reg[W-1:0];
    assign ny_ext = {a_ny_reg[W-1], a_ny_reg};

    assign s_sum     = {1'b0, b_sqx_reg} + {1'b0, b_sqz_reg};
    assign horiz     = s_sum <= {{(2*W+1-2*M){1'b0}}, b_rad2_reg};
    assign up_lt     = b_up_reg < b_down_reg;
    assign up_half   = b_up_reg >>> 1;
    assign down_half = b_down_reg >>> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg   <= {cyl_x[W-1], cyl_x} - {cx_c[W-1], cx_c};
            a_dz_reg   <= {cyl_z[W-1], cyl_z} - {cz_c[W-1], cz_c};
            a_top_reg  <= {cyl_y[W-1], cyl_y} + {2'b00, cyl_height};
            a_up_reg   <= {box_max_y[W-1], box_max_y} - {cyl_y[W-1], cyl_y};
            a_cylt_reg <= cyl_y < box_max_y;
            a_ny_reg   <= box_min_y;
            a_rad_reg  <= cyl_radius;

            b_sqx_reg  <= ax_w * ax_w;
            b_sqz_reg  <= az_w * az_w;
            b_rad2_reg <= a_rad_reg * a_rad_reg;
            b_up_reg   <= {a_up_reg[W], a_up_reg};
            b_down_reg <= {a_top_reg[W], a_top_reg} - {ny_ext[W], ny_ext};
            b_vert_reg <= a_cylt_reg && (ny_ext < a_top_reg);
            b_sx_reg   <= a_dx_reg[W];
            b_sz_reg   <= a_dz_reg[W];
            b_ax_reg   <= ax_w[M-1:0];
            b_az_reg   <= az_w[M-1:0];
            b_rad_reg  <= a_rad_reg;

            c_s_reg         <= s_sum[2*M-1:0];
            c_ctl_reg.hit   <= b_vert_reg && horiz;
            c_ctl_reg.s_nz  <= s_sum != '0;
            c_ctl_reg.use_h <= 1'b0;
            c_ctl_reg.sx    <= b_sx_reg;
            c_ctl_reg.sz    <= b_sz_reg;
            c_ax_reg        <= b_ax_reg;
            c_az_reg        <= b_az_reg;
            c_rad_reg       <= b_rad_reg;
            c_vpush_reg     <= up_lt ? up_half[W-1:0] : W'(-down_half);
            c_vmag_reg      <= up_lt ? b_up_reg[W-1:0] : b_down_reg[W-1:0];
        end
    end

    assign out_vld = c_vld_reg;
    assign s       = c_s_reg;
    assign ctl     = c_ctl_reg;
    assign ax      = c_ax_reg;
    assign az      = c_az_reg;
    assign rad     = c_rad_reg;
    assign vpush   = c_vpush_reg;
    assign vmag    = c_vmag_reg;

endmodule

// ----- hdl/bccp_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module bccp_sqrt #(
    parameter int M      = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2*M-1:0]    val,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [M-1:0]      root,
    output logic [SIDE_W-1:0] side_out
);
    import bccp_pkg::*;

    logic              vld_reg  [M+1];
    logic [M+1:0]      rem_reg  [M+1];
    logic [M-1:0]      root_reg [M+1];
    logic [2*M-1:0]    val_reg  [M+1];
    logic [SIDE_W-1:0] side_reg [M+1];

    logic              vld_next  [M+1];
    logic [M+1:0]      rem_next  [M+1];
    logic [M-1:0]      root_next [M+1];
    logic [2*M-1:0]    val_next  [M+1];
    logic [SIDE_W-1:0] side_next [M+1];

    logic [M+1:0] cur, trial;

    always_comb
    begin
        cur   = '0;
        trial = '0;
        vld_next[0]  = in_vld;
        rem_next[0]  = '0;
        root_next[0] = '0;
        val_next[0]  = val;
        side_next[0] = side_in;
        for (int k = 0; k < M; k++)
        begin
            cur   = {rem_reg[k][M-1:0], val_reg[k][2*M-1 -: 2]};
            trial = {root_reg[k], 2'b01};
            if (cur >= trial)
            begin
                rem_next[k+1]  = cur - trial;
                root_next[k+1] = {root_reg[k][M-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1]  = cur;
                root_next[k+1] = {root_reg[k][M-2:0], 1'b0};
            end
            vld_next[k+1]  = vld_reg[k];
            val_next[k+1]  = {val_reg[k][2*M-3:0], 2'b00};
            side_next[k+1] = side_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= M; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k <= M; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= M; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                val_reg[k]  <= val_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_vld  = vld_reg[M];
    assign root     = root_reg[M];
    assign side_out = side_reg[M];

endmodule

// ----- hdl/bccp_div.sv -----
// Pipelined two-lane restoring divider with shared divisor, one quotient bit per stage.
module bccp_div #(
    parameter int M      = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2*M-1:0]    num_x,
    input  logic [2*M-1:0]    num_z,
    input  logic [M:0]        den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [M-1:0]      quo_x,
    output logic [M-1:0]      quo_z,
    output logic [SIDE_W-1:0] side_out
);
    import bccp_pkg::*;

    // lane 0 is x, lane 1 is z
    logic              vld_reg  [M+1];
    logic [M:0]        den_reg  [M+1];
    logic [SIDE_W-1:0] side_reg [M+1];
    logic [M:0]        rem_reg  [M+1][2];
    logic [M-1:0]      low_reg  [M+1][2];
    logic [M-1:0]      q_reg    [M+1][2];

    logic              vld_next  [M+1];
    logic [M:0]        den_next  [M+1];
    logic [SIDE_W-1:0] side_next [M+1];
    logic [M:0]        rem_next  [M+1][2];
    logic [M-1:0]      low_next  [M+1][2];
    logic [M-1:0]      q_next    [M+1][2];

    logic [M+1:0] cur;
    logic         ge;

    always_comb
    begin
        cur = '0;
        ge  = 1'b0;
        vld_next[0]    = in_vld;
        den_next[0]    = den;
        side_next[0]   = side_in;
        rem_next[0][0] = {1'b0, num_x[2*M-1:M]};
        rem_next[0][1] = {1'b0, num_z[2*M-1:M]};
        low_next[0][0] = num_x[M-1:0];
        low_next[0][1] = num_z[M-1:0];
        q_next[0][0]   = '0;
        q_next[0][1]   = '0;
        for (int k = 0; k < M; k++)
        begin
            vld_next[k+1]  = vld_reg[k];
            den_next[k+1]  = den_reg[k];
            side_next[k+1] = side_reg[k];
            for (int l = 0; l < 2; l++)
            begin
                cur = {rem_reg[k][l], low_reg[k][l][M-1]};
                ge  = cur >= {1'b0, den_reg[k]};
                rem_next[k+1][l] = ge ? (M+1)'(cur - {1'b0, den_reg[k]}) : cur[M:0];
                low_next[k+1][l] = {low_reg[k][l][M-2:0], 1'b0};
                q_next[k+1][l]   = {q_reg[k][l][M-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= M; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k <= M; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= M; k++)
            begin
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    low_reg[k][l] <= low_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                end
            end
        end
    end

    assign out_vld  = vld_reg[M];
    assign quo_x    = q_reg[M][0];
    assign quo_z    = q_reg[M][1];
    assign side_out = side_reg[M];

endmodule

// ----- hdl/box_cylinder_collision_push.sv -----
// Box versus upright cylinder collision with half push vector. One beat in
// carries an axis-aligned box and a cylinder (base point, radius, height) in
// signed fixed point with 16 fraction bits; one beat out gives the hit flag
// and half of the push that separates the pair, applied to the cylinder (the
// box takes the negation). A new beat is taken every cycle unless a held result
// stalls the pipeline; its depth is set by the bit-serial pipelines of the
// square root and the divider, each one stage per result bit. The whole
// pipeline advances together and holds while a result waits on out_stall,
// so in_stall follows out_valid and out_stall directly.
module box_cylinder_collision_push #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] cyl_x,
    input  logic signed [COORD_WIDTH-1:0] cyl_y,
    input  logic signed [COORD_WIDTH-1:0] cyl_z,
    input  logic        [COORD_WIDTH-2:0] cyl_radius,
    input  logic        [COORD_WIDTH-2:0] cyl_height,
    input  logic signed [COORD_WIDTH-1:0] box_min_x,
    input  logic signed [COORD_WIDTH-1:0] box_min_y,
    input  logic signed [COORD_WIDTH-1:0] box_min_z,
    input  logic signed [COORD_WIDTH-1:0] box_max_x,
    input  logic signed [COORD_WIDTH-1:0] box_max_y,
    input  logic signed [COORD_WIDTH-1:0] box_max_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] push_x,
    output logic signed [COORD_WIDTH-1:0] push_y,
    output logic signed [COORD_WIDTH-1:0] push_z
);
    import bccp_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int M     = W - 1;
    localparam int CTL_W = $bits(bccp_ctl_t);
    localparam int SQ_W  = CTL_W + 3 * M + 2 * W;  // ctl, ax, az, rad, vpush, vmag
    localparam int DV_W  = CTL_W + W;              // ctl, vpush

    logic en;

    // front end outputs
    logic         f_vld;
    logic [2*M-1:0] f_s;
    bccp_ctl_t    f_ctl;
    logic [M-1:0] f_ax, f_az, f_rad;
    logic [W-1:0] f_vpush, f_vmag;

    // square root outputs
    logic            q_vld;
    logic [M-1:0]    q_len;
    logic [SQ_W-1:0] q_side;
    bccp_ctl_t       q_ctl;
    logic [M-1:0]    q_ax, q_az, q_rad, depth;
    logic [W-1:0]    q_vpush, q_vmag;

    // depth / direction stage
    logic         d_vld_reg;
    bccp_ctl_t    d_ctl_reg;
    bccp_ctl_t    d_ctl_next;
    logic [M-1:0] d_ax_reg, d_az_reg, d_depth_reg;
    logic [M:0]   d_den_reg;
    logic [W-1:0] d_vpush_reg;

    // product stage, feeds the divider
    logic           e_vld_reg;
    bccp_ctl_t      e_ctl_reg;
    logic [2*M-1:0] e_numx_reg, e_numz_reg;
    logic [M:0]     e_den_reg;
    logic [W-1:0]   e_vpush_reg;

    // divider outputs
    logic            v_vld;
    logic [M-1:0]    v_qx, v_qz;
    logic [DV_W-1:0] v_side;
    bccp_ctl_t       v_ctl;
    logic [W-1:0]    v_vpush, qx_w, qz_w;

    // output register
    logic         out_vld_reg, hit_reg;
    logic [W-1:0] px_reg, py_reg, pz_reg;

    // Everything moves together unless the output beat is held.
    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    bccp_front #(.W(W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (in_valid),
        .cyl_x      (cyl_x),
        .cyl_y      (cyl_y),
        .cyl_z      (cyl_z),
        .cyl_radius (cyl_radius),
        .cyl_height (cyl_height),
        .box_min_x  (box_min_x),
        .box_min_y  (box_min_y),
        .box_min_z  (box_min_z),
        .box_max_x  (box_max_x),
        .box_max_y  (box_max_y),
        .box_max_z  (box_max_z),
        .out_vld    (f_vld),
        .s          (f_s),
        .ctl        (f_ctl),
        .ax         (f_ax),
        .az         (f_az),
        .rad        (f_rad),
        .vpush      (f_vpush),
        .vmag       (f_vmag)
    );

    // On a hit S <= radius^2, so only the low 2*(W-1) bits of S matter and
    // the root fits W-1 bits; ax and az never exceed the root.
    bccp_sqrt #(.M(M), .SIDE_W(SQ_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .val      (f_s),
        .side_in  ({f_ctl, f_ax, f_az, f_rad, f_vpush, f_vmag}),
        .out_vld  (q_vld),
        .root     (q_len),
        .side_out (q_side)
    );

    assign {q_ctl, q_ax, q_az, q_rad, q_vpush, q_vmag} = q_side;
    assign depth = q_rad - q_len;

    // Horizontal push only when it is the shallower one and the
    // direction is defined (base point outside the footprint).
    always_comb
    begin
        d_ctl_next       = q_ctl;
        d_ctl_next.use_h = q_ctl.hit && q_ctl.s_nz && ({1'b0, depth} < q_vmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg   <= q_vld;
            e_vld_reg   <= d_vld_reg;
            out_vld_reg <= v_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ctl_reg       <= d_ctl_next;
            d_ax_reg        <= q_ax;
            d_az_reg        <= q_az;
            d_depth_reg     <= depth;
            d_den_reg       <= {q_len, 1'b0};
            d_vpush_reg     <= q_vpush;

            e_ctl_reg   <= d_ctl_reg;
            e_numx_reg  <= d_ax_reg * d_depth_reg;
            e_numz_reg  <= d_az_reg * d_depth_reg;
            e_den_reg   <= d_den_reg;
            e_vpush_reg <= d_vpush_reg;
        end
    end

    // quotient is at most depth/2, so W-1 quotient bits suffice
    bccp_div #(.M(M), .SIDE_W(DV_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (e_vld_reg),
        .num_x    (e_numx_reg),
        .num_z    (e_numz_reg),
        .den      (e_den_reg),
        .side_in  ({e_ctl_reg, e_vpush_reg}),
        .out_vld  (v_vld),
        .quo_x    (v_qx),
        .quo_z    (v_qz),
        .side_out (v_side)
    );

    assign {v_ctl, v_vpush} = v_side;
    assign qx_w = {1'b0, v_qx};
    assign qz_w = {1'b0, v_qz};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= v_ctl.hit;
            px_reg  <= v_ctl.use_h ? (v_ctl.sx ? -qx_w : qx_w) : '0;
            pz_reg  <= v_ctl.use_h ? (v_ctl.sz ? -qz_w : qz_w) : '0;
            py_reg  <= (v_ctl.hit && !v_ctl.use_h) ? v_vpush : '0;
        end
    end

    assign out_valid = out_vld_reg;
    assign hit       = hit_reg;
    assign push_x    = px_reg;
    assign push_y    = py_reg;
    assign push_z    = pz_reg;

    // a miss carries no push
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> push_x == '0 && push_y == '0 && push_z == '0)
        else $error("push nonzero without hit");

    // vertical and horizontal pushes never mix
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && push_y != '0 |-> push_x == '0 && push_z == '0)
        else $error("vertical and horizontal push both set");

    // a held output beat holds the input side too
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output held");

    // held beat keeps its value across the pipeline freeze
    a_hold_val: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid && $stable(hit))
        else $error("output changed while pipeline frozen");

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the box versus upright cylinder collision push block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W         = 32;
    localparam int LATENCY   = 2 * W + 6;
    localparam int MAX_CYC   = 400000;

    // One beat of input: cylinder then box corners.
    typedef struct {
        logic signed [W-1:0] cx, cy, cz;
        logic [W-2:0]        rad, hgt;
        logic signed [W-1:0] nx, ny, nz, px, py, pz;
    } pair_t;

    // One beat of output.
    typedef struct {
        logic                hit;
        logic signed [W-1:0] push_x, push_y, push_z;
    } push_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [W-1:0] cyl_x = '0, cyl_y = '0, cyl_z = '0;
    logic [W-2:0] cyl_radius = '0, cyl_height = '0;
    logic signed [W-1:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
    logic signed [W-1:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic signed [W-1:0] push_x, push_y, push_z;

    push_t expected_pushes[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    hold_off = 0;     // cycles the receiver must still refuse beats
    int    rx_wait = 0;      // cycles the receiver still idles after a beat
    bit    out_acc = 1'b0;   // a result beat was taken at the last rising edge
    bit    rx_random = 1'b1; // random receiver stalls enabled
    bit    tx_random = 1'b1; // random sender gaps enabled

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    box_cylinder_collision_push #(.COORD_WIDTH(W)) u_dut (.*);

    // Exact predictor in wide integers: products up to 2*W+2 bits.
    function automatic push_t predict_push(pair_t p);
        push_t r;
        logic signed [W+1:0] cx, cz, clx, clz, dx, dz, up, down, vpush;
        logic [W+1:0] ax, az, vmag, len, depth;
        logic [2*W+3:0] s, r2, sq;
        logic [3*W+3:0] qx, qz;
        logic vert;
        r = '{1'b0, '0, '0, '0};
        cx = p.cx;
        cz = p.cz;
        clx = (cx < p.nx) ? p.nx : cx;
        clx = (clx > p.px) ? p.px : clx;
        clz = (cz < p.nz) ? p.nz : cz;
        clz = (clz > p.pz) ? p.pz : clz;
        dx = cx - clx;
        dz = cz - clz;
        ax = dx < 0 ? -dx : dx;
        az = dz < 0 ? -dz : dz;
        s = ax * ax + az * az;
        r2 = p.rad * p.rad;
        vert = ($signed({2'b0, p.hgt}) + p.cy > p.ny) && (p.cy < p.py);
        if (!(vert && s <= r2))
            return r;
        r.hit = 1'b1;
        up = p.py - p.cy;
        down = p.cy + $signed({3'b0, p.hgt}) - p.ny;
        if (up < down)
        begin
            vpush = up / 2;
            vmag = up;
        end
        else
        begin
            vpush = -(down / 2);
            vmag = down;
        end
        // Floor square root, bit by bit.
        len = '0;
        for (int b = W + 1; b >= 0; b--)
        begin
            sq = (len | ((W+2)'(1) << b)) * (len | ((W+2)'(1) << b));
            if (sq <= s)
                len = len | ((W+2)'(1) << b);
        end
        depth = p.rad - len;
        if (s != 0 && depth < vmag)
        begin
            qx = (ax * depth) / (2 * len);
            qz = (az * depth) / (2 * len);
            r.push_x = dx < 0 ? -qx[W-1:0] : qx[W-1:0];
            r.push_z = dz < 0 ? -qz[W-1:0] : qz[W-1:0];
        end
        else
            r.push_y = vpush[W-1:0];
        return r;
    endfunction

    // Send one beat after a random gap; hold until accepted. Valid stays up
    // after the beat so back-to-back beats need no extra edge; drain drops it.
    task automatic send_pair(pair_t p);
        int gap;
        gap = tx_random ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cyl_x <= p.cx; cyl_y <= p.cy; cyl_z <= p.cz;
        cyl_radius <= p.rad; cyl_height <= p.hgt;
        box_min_x <= p.nx; box_min_y <= p.ny; box_min_z <= p.nz;
        box_max_x <= p.px; box_max_y <= p.py; box_max_z <= p.pz;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pushes.push_back(predict_push(p));
        @(negedge clk);
    endtask

    function automatic logic signed [W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return ($signed($urandom_range(0, 40)) - 20) <<< 16;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    // Well-formed pair near each other, so hits and both push axes come up.
    function automatic pair_t near_pair();
        pair_t p;
        logic signed [W-1:0] bx, by, bz;
        bx = rand_coord();
        by = rand_coord() >>> 2;
        bz = rand_coord();
        p.nx = bx; p.ny = by; p.nz = bz;
        p.px = bx + $urandom_range(0, 32'h0008_0000);
        p.py = by + $urandom_range(0, 32'h0008_0000);
        p.pz = bz + $urandom_range(0, 32'h0008_0000);
        p.cx = bx + $signed($urandom_range(0, 32'h0010_0000)) - 32'h0004_0000;
        p.cz = bz + $signed($urandom_range(0, 32'h0010_0000)) - 32'h0004_0000;
        p.cy = by + $signed($urandom_range(0, 32'h000C_0000)) - 32'h0004_0000;
        p.rad = (W-1)'($urandom_range(0, 32'h0006_0000));
        p.hgt = (W-1)'($urandom_range(0, 32'h0006_0000));
        if ($urandom_range(0, 15) == 0)
            p.rad = (W-1)'($urandom);
        return p;
    endfunction

    function automatic pair_t noise_pair();
        pair_t p;
        p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
        p.rad = (W-1)'($urandom); p.hgt = (W-1)'($urandom);
        p.nx = $urandom; p.ny = $urandom; p.nz = $urandom;
        p.px = $urandom; p.py = $urandom; p.pz = $urandom;
        return p;
    endfunction

    // Receiver: a forced hold-off stretch, or a random idle count per beat.
    always @(negedge clk)
    begin
        int w;
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
        begin
            w = rx_wait;
            if (out_acc)
                w = rx_random ? int'($urandom_range(0, 15)) : 0;
            out_stall <= (w > 0);
            rx_wait <= (w > 0) ? w - 1 : 0;
        end
    end

    // Checker: compare each accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        push_t e;
        cycles <= cycles + 1;
        out_acc <= rst_n && out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pushes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat hit=%0b", hit);
            end
            else
            begin
                e = expected_pushes.pop_front();
                if (hit !== e.hit || push_x !== e.push_x || push_y !== e.push_y
                    || push_z !== e.push_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit=%0b %0d %0d %0d got hit=%0b %0d %0d %0d",
                                 e.hit, e.push_x, e.push_y, e.push_z,
                                 hit, push_x, push_y, push_z);
                end
            end
        end
        if (cycles > MAX_CYC)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_pushes.size() != 0)
            @(negedge clk);
    endtask

    function automatic pair_t mk(int cx, int cy, int cz, int rad, int hgt,
                                 int nx, int ny, int nz, int px, int py, int pz);
        pair_t p;
        p = '{cx, cy, cz, rad[W-2:0], hgt[W-2:0], nx, ny, nz, px, py, pz};
        return p;
    endfunction

    // Directed: extremes, touching faces, zero distance, inverted boxes.
    task automatic test_directed();
        localparam int U = 32'h0001_0000;
        int mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        // base point inside footprint: zero distance -> vertical push
        send_pair(mk(0, 0, 0, U, 2*U, -U, U, -U, U, 3*U, U));
        send_pair(mk(0, -U, 0, U, 2*U, -U, 0, -U, U, 5*U, U));
        // horizontal push, both signs
        send_pair(mk(2*U, 0, 0, 3*U/2, 4*U, -U, 0, -U, U, 4*U, U));
        send_pair(mk(-2*U, 0, -2*U, 2*U, 4*U, -U, 0, -U, U, 4*U, U));
        // tangent horizontally (a hit), strict vertical touches (no hit)
        send_pair(mk(2*U, 0, 0, U, 4*U, -U, 0, -U, U, 4*U, U));
        send_pair(mk(0, 4*U, 0, U, 4*U, -U, 0, -U, U, 4*U, U));
        send_pair(mk(0, -4*U, 0, U, 4*U, -U, 0, -U, U, 4*U, U));
        // extremes
        send_pair(mk(mx, mx, mx, mx, mx, mn, mn, mn, mx, mx, mx));
        send_pair(mk(mn, mn, mn, mx, mx, mn, mn, mn, mx, mx, mx));
        send_pair(mk(mx, mn, mn, mx, mx, mn, mn, mn, mn, mx, mn));
        send_pair(mk(mn, 0, mx, mx, mx, mx, mn, mx, mx, mx, mx));
        send_pair(mk(-1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(mk(0, 0, 0, mx, mx, 0, 0, 0, 0, 0, 0));
        // inverted box
        send_pair(mk(0, 0, 0, 2*U, 2*U, U, U, U, -U, -U, -U));
        send_pair(mk(0, -U, 0, 2*U, 3*U, U, 2*U, U, -U, U, -U));
        send_pair(mk(U, 0, 0, 3*U, 4*U, 2*U, -U, 2*U, -U, 4*U, -U));
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_pair($urandom_range(0, 4) == 0 ? noise_pair() : near_pair());
    endtask

    // Receiver holds off for long while the sender keeps offering beats.
    task automatic test_backpressure();
        tx_random = 1'b0;
        hold_off = 3 * LATENCY;
        test_random(200);
        tx_random = 1'b1;
        drain();
    endtask

    // Full-rate stretch with no idling on either side.
    task automatic test_streaming();
        rx_random = 1'b0;
        tx_random = 1'b0;
        test_random(150);
        drain();
        rx_random = 1'b1;
        tx_random = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(300);
        drain();
        test_backpressure();
        test_streaming();
        test_random(100);
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatches == 0 && expected_pushes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
